[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg - shared types and constants of the double-ended queue
// opcodes, result status codes and the command that steers the cell row
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_REVERSE    = 3'd5,
        OP_DUMP       = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what every cell of the row does this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS_FRONT,
        CELL_INS_BACK,
        CELL_DEL_FRONT,
        CELL_ROT_LEFT,
        CELL_ROT_RIGHT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic [WORD_W-1:0] ins;   // word to insert
        logic [WORD_W-1:0] head;  // word in the first cell
        logic [WORD_W-1:0] tail;  // word in the last occupied cell
    } t_cell_ctl;

endpackage

[rtl/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell - one storage cell of the queue row
// holds one word and takes it from a neighbour or the broadcast words
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                        i_clk,
    input  dq_pkg::t_cell_ctl           i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]  i_count,
    input  logic [dq_pkg::WORD_W-1:0]   i_left,
    input  logic [dq_pkg::WORD_W-1:0]   i_right,
    output logic [dq_pkg::WORD_W-1:0]   o_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);
    localparam bit            IS_FIRST = (IDX == 0);

    logic [dq_pkg::WORD_W-1:0] r_word;
    logic [dq_pkg::WORD_W-1:0] n_word;
    logic                      w_at_count;
    logic                      w_occupied;
    logic                      w_is_tail;

    assign w_at_count = (i_count == POS);
    assign w_occupied = (POS < i_count);
    assign w_is_tail  = (i_count == POS_NEXT);

    always_comb begin
        n_word = r_word;
        case (i_ctl.cmd)
            dq_pkg::CELL_INS_FRONT: n_word = IS_FIRST ? i_ctl.ins : i_left;
            dq_pkg::CELL_INS_BACK: begin
                if (w_at_count) begin
                    n_word = i_ctl.ins;
                end
            end
            dq_pkg::CELL_DEL_FRONT: n_word = i_right;
            dq_pkg::CELL_ROT_LEFT: begin
                if (w_occupied) begin
                    n_word = w_is_tail ? i_ctl.head : i_right;
                end
            end
            dq_pkg::CELL_ROT_RIGHT: begin
                if (w_occupied) begin
                    n_word = IS_FIRST ? i_ctl.tail : i_left;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[rtl/double_ended_queue_with_reverse.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse - bounded deque of signed words
// a row of shifting cells with a reversal flag and a streaming dump
// ----------------------------------------------------------------------------
// usage
//   input channel : i_valid / o_ready, word = i_opcode + i_value
//   output channel: o_valid / i_ready, word = o_data + o_status + o_last
//   push, pop, clear and reverse give one result word in the cycle after the
//   input word is taken; a new input word can be taken every cycle while
//   the output register drains
//   dump of n words takes the input word, then gives one result per cycle
//   while the receiver takes them, n results in all; no input word is taken
//   until the last dump word has been loaded into the output register
//   the dump walks the cell row by rotation, one cell step per word, so the
//   row ends up as it started
//   a stalled receiver holds the output register; the block then takes
//   no further input and the dump pauses in place
//   reset (i_rst_n low, synchronous) empties the queue, clears the reversal
//   flag and drops any pending result; no clearing pass is needed
//   push to a full queue answers full, pop or dump of an empty queue
//   answers empty with data zero
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_opcode,
    input  logic signed [dq_pkg::WORD_W-1:0]  i_value,
    // output channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [dq_pkg::WORD_W-1:0]  o_data,
    output logic [1:0]                        o_status,
    output logic                              o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // control state
    t_state          r_state,  n_state;
    logic [CW-1:0]   r_count,  n_count;
    logic            r_rev,    n_rev;
    logic [CW-1:0]   r_left,   n_left;
    // output register
    logic            r_valid,  n_valid;
    logic [dq_pkg::WORD_W-1:0] r_data, n_data;
    dq_pkg::t_status r_status, n_status;
    logic            r_last,   n_last;

    // cell row
    logic [dq_pkg::WORD_W-1:0] w_cell [DEPTH];
    logic [dq_pkg::WORD_W-1:0] w_tail;
    dq_pkg::t_cell_cmd         w_cmd;
    dq_pkg::t_cell_ctl         w_ctl;

    logic   w_out_free;
    logic   w_accept;
    logic   w_empty;
    logic   w_full;
    logic   w_phys_front;
    dq_pkg::t_op w_op;

    assign w_op       = dq_pkg::t_op'(i_opcode);
    assign w_out_free = !r_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == FULL_COUNT);

    // the logical front is the physical front unless the order is reversed
    assign w_phys_front = ((w_op == dq_pkg::OP_PUSH_FRONT) || (w_op == dq_pkg::OP_POP_FRONT))
                          != r_rev;

    // word in the last occupied cell, one-hot picked by the fill count
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail = w_tail | (w_cell[i] & {dq_pkg::WORD_W{r_count == CW'(i + 1)}});
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rev    = r_rev;
        n_left   = r_left;
        n_valid  = r_valid && !i_ready;
        n_data   = r_data;
        n_status = r_status;
        n_last   = r_last;
        w_cmd    = dq_pkg::CELL_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid  = 1'b1;
                    n_data   = '0;
                    n_status = dq_pkg::ST_OK;
                    n_last   = 1'b1;
                    case (w_op) inside
                        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = dq_pkg::ST_FULL;
                            end else begin
                                w_cmd   = w_phys_front ? dq_pkg::CELL_INS_FRONT
                                                       : dq_pkg::CELL_INS_BACK;
                                n_count = r_count + ONE;
                            end
                        end
                        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
                            if (w_empty) begin
                                n_status = dq_pkg::ST_EMPTY;
                            end else begin
                                if (w_phys_front) begin
                                    n_data = w_cell[0];
                                    w_cmd  = dq_pkg::CELL_DEL_FRONT;
                                end else begin
                                    n_data = w_tail;
                                end
                                n_count = r_count - ONE;
                            end
                        end
                        dq_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_rev   = 1'b0;
                        end
                        dq_pkg::OP_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        dq_pkg::OP_DUMP: begin
                            if (w_empty) begin
                                n_status = dq_pkg::ST_EMPTY;
                            end else begin
                                // results are streamed from the dump state
                                n_valid = r_valid && !i_ready;
                                n_state = S_DUMP;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            // unused opcode: plain ok result
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    n_valid  = 1'b1;
                    n_status = dq_pkg::ST_OK;
                    n_last   = (r_left == ONE);
                    // forward: take the head, rotate left; reversed: take the tail, rotate right
                    n_data   = r_rev ? w_tail : w_cell[0];
                    w_cmd    = r_rev ? dq_pkg::CELL_ROT_RIGHT : dq_pkg::CELL_ROT_LEFT;
                    n_left   = r_left - ONE;
                    if (r_left == ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
        r_data   <= n_data;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign w_ctl.cmd  = w_cmd;
    assign w_ctl.ins  = i_value;
    assign w_ctl.head = w_cell[0];
    assign w_ctl.tail = w_tail;

    // row of cells, cell 0 holds the physical front
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [dq_pkg::WORD_W-1:0] w_left;
        logic [dq_pkg::WORD_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        dq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_cell[g])
        );
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_last   = r_last;

    // fill count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count beyond depth");

    // a dump leaves the fill count untouched
    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> (r_count == $past(r_count)))
        else $error("fill count moved during dump");

    // a word that is not the last of its item only comes from a running dump
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_state == S_DUMP))
        else $error("non-final word outside dump");

    // empty answers carry zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == dq_pkg::ST_EMPTY)) |-> (r_data == '0))
        else $error("empty status with data");

endmodule
